/* sv/banked_flash_command_controller_defines.svh */
// assertion macros shared by the flash controller
`ifndef BANKED_FLASH_COMMAND_CONTROLLER_DEFINES_SVH
`define BANKED_FLASH_COMMAND_CONTROLLER_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define BFCC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition must hold in the cycle after the trigger
`define BFCC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/bfcc_pkg.sv */
`timescale 1ns / 1ps

package bfcc_pkg;

   // command interface addresses and codes
   localparam logic [15:0] ADDR_A        = 16'h5555;
   localparam logic [15:0] ADDR_B        = 16'h2AAA;
   localparam logic [7:0]  CODE_UNLOCK_A = 8'hAA;
   localparam logic [7:0]  CODE_UNLOCK_B = 8'h55;
   localparam logic [7:0]  CODE_BANK     = 8'hB0;
   localparam logic [7:0]  CODE_ID       = 8'h90;
   localparam logic [7:0]  CODE_PROGRAM  = 8'hA0;
   localparam logic [7:0]  CODE_ERASE    = 8'h80;
   localparam logic [7:0]  CODE_CHIP     = 8'h10;
   localparam logic [7:0]  CODE_SECTOR   = 8'h30;
   localparam logic [7:0]  CODE_STOP     = 8'hF0;

   localparam logic [7:0]  ERASED_BYTE   = 8'hFF;
   localparam logic [15:0] SECTOR_MASK   = 16'hF000;
   localparam int          SECTOR_W      = 12;
   localparam int          OFF_W         = 16;
   localparam int          PAGE_W        = 7;
   localparam logic [PAGE_W-1:0] PAGE_TAIL = 7'd126;

   localparam int          CSR_IDX_W     = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAKER_ID  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_ID = 1'd1;

   typedef enum logic [3:0] {
      MODE_IDLE, MODE_UNLOCKED1, MODE_COMMAND, MODE_BANKSEL,
      MODE_ID1, MODE_ID2, MODE_IDX1, MODE_IDX2, MODE_IDX3,
      MODE_PROGRAM, MODE_AFTERPROG, MODE_PAGE,
      MODE_ER1, MODE_ER2, MODE_ER3
   } mode_type;

   typedef enum logic [1:0] {
      PH_SWEEP, PH_IDLE, PH_EXEC
   } phase_type;

   typedef enum logic [1:0] {
      RSEL_ZERO, RSEL_MEM, RSEL_ID
   } rsel_type;

   typedef struct packed {
      logic     capture;
      logic     exec;
      rsel_type rsel;
      logic     error;
      logic     mem_write;
      logic     bank_load;
      logic     page_load;
      logic     page_dec;
      logic     chip_start;
      logic     sector_start;
      logic     sweep_step;
   } dp_cmd_type;

   typedef struct packed {
      logic is_write;
      logic addr_a;
      logic addr_b;
      logic addr_zero;
      logic d_unlock_a;
      logic d_unlock_b;
      logic d_bank;
      logic d_id;
      logic d_program;
      logic d_erase;
      logic d_chip;
      logic d_sector;
      logic d_stop;
      logic page_last;
      logic sweep_last;
      logic out_free;
   } dp_sts_type;

endpackage

/* sv/bfcc_dp.sv */
`timescale 1ns / 1ps

module bfcc_dp
   import bfcc_pkg::*;
#(
   parameter int BANKS      = 2,
   parameter int BANK_BYTES = 65536
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_sts_type           sts,
   input  logic [23:0]          req_tdata,
   input  logic [0:0]           req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic [0:0]           rsp_tuser,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata
);

   localparam int CELLS   = BANKS * BANK_BYTES;
   localparam int CELL_AW = $clog2(CELLS);
   localparam int BANK_W  = (BANKS > 1) ? $clog2(BANKS) : 1;

   // address reduction into one bank: compare against every multiple in parallel
   function automatic logic [OFF_W-1:0] bank_mod(input logic [15:0] a);
      logic [20:0] sub;
      sub = '0;
      for (int k = 1; k <= 16; k++) begin
         if (21'(a) >= 21'(k * BANK_BYTES)) sub = 21'(k * BANK_BYTES);
      end
      return OFF_W'(21'(a) - sub);
   endfunction

   logic [BANK_W-1:0]   bank_tab [256];
   logic [7:0]          cells_mem [CELLS];

   logic [15:0]         addr_ff;
   logic [7:0]          wdata_ff;
   logic                kind_ff;
   logic [CELL_AW-1:0]  cell_addr_ff;
   logic [CELL_AW-1:0]  cell_addr_in;
   logic [7:0]          rd_q_ff;
   logic [BANK_W-1:0]   bank_ff;
   logic [PAGE_W-1:0]   page_left_ff;
   logic [7:0]          maker_id_ff;
   logic [7:0]          device_id_ff;
   logic                chip_ff;
   logic [CELL_AW-1:0]  lin_ff;
   logic [OFF_W-1:0]    off_ff;
   logic [OFF_W-1:0]    off_in;
   logic [SECTOR_W-1:0] cnt_ff;
   logic                rsp_valid_ff;
   logic [7:0]          rdata_ff;
   logic                err_ff;
   logic [7:0]          rdata_in;
   logic [CELL_AW-1:0]  bank_base;
   logic [CELL_AW-1:0]  sweep_addr;

   for (genvar g = 0; g < 256; g++) begin : g_bank_tab
      assign bank_tab[g] = BANK_W'(g % BANKS);
   end

   assign bank_base    = CELL_AW'(bank_ff) * CELL_AW'(BANK_BYTES);
   assign cell_addr_in = bank_base + CELL_AW'(bank_mod(req_tdata[15:0]));
   assign sweep_addr   = chip_ff ? lin_ff : bank_base + CELL_AW'(off_ff);
   assign off_in       = (({1'b0, off_ff} + 17'd1) == 17'(BANK_BYTES)) ? '0 : off_ff + 1'b1;

   // request capture and memory read at the accept edge; erase-walk and program writes to the array
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         addr_ff      <= req_tdata[15:0];
         wdata_ff     <= req_tdata[23:16];
         kind_ff      <= req_tuser[0];
         cell_addr_ff <= cell_addr_in;
         rd_q_ff      <= cells_mem[cell_addr_in];
      end
      if (cmd.sweep_step) begin
         cells_mem[sweep_addr] <= ERASED_BYTE;
      end else if (cmd.mem_write) begin
         cells_mem[cell_addr_ff] <= wdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff      <= '0;
         page_left_ff <= '0;
         maker_id_ff  <= 8'd98;
         device_id_ff <= 8'd19;
         chip_ff      <= 1'b1;
         lin_ff       <= '0;
         off_ff       <= '0;
         cnt_ff       <= '0;
      end else begin
         if (cmd.bank_load) bank_ff <= bank_tab[wdata_ff];
         if (cmd.page_load) page_left_ff <= PAGE_TAIL;
         else if (cmd.page_dec) page_left_ff <= page_left_ff - 1'b1;
         if (csr_we) begin
            unique case (csr_index)
               CSR_MAKER_ID:  maker_id_ff  <= csr_wdata;
               CSR_DEVICE_ID: device_id_ff <= csr_wdata;
            endcase
         end
         if (cmd.chip_start) begin
            chip_ff <= 1'b1;
            lin_ff  <= '0;
         end else if (cmd.sector_start) begin
            chip_ff <= 1'b0;
            off_ff  <= bank_mod(addr_ff & SECTOR_MASK);
            cnt_ff  <= '0;
         end else if (cmd.sweep_step) begin
            lin_ff <= lin_ff + 1'b1;
            off_ff <= off_in;
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   always_comb begin
      unique case (cmd.rsel)
         RSEL_MEM: rdata_in = rd_q_ff;
         RSEL_ID:  rdata_in = addr_ff[0] ? device_id_ff : maker_id_ff;
         default:  rdata_in = '0;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.exec) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.exec) begin
         rdata_ff <= rdata_in;
         err_ff   <= cmd.error;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rdata_ff;
   assign rsp_tuser[0] = err_ff;

   always_comb begin
      sts.is_write   = kind_ff;
      sts.addr_a     = (addr_ff == ADDR_A);
      sts.addr_b     = (addr_ff == ADDR_B);
      sts.addr_zero  = (addr_ff == 16'd0);
      sts.d_unlock_a = (wdata_ff == CODE_UNLOCK_A);
      sts.d_unlock_b = (wdata_ff == CODE_UNLOCK_B);
      sts.d_bank     = (wdata_ff == CODE_BANK);
      sts.d_id       = (wdata_ff == CODE_ID);
      sts.d_program  = (wdata_ff == CODE_PROGRAM);
      sts.d_erase    = (wdata_ff == CODE_ERASE);
      sts.d_chip     = (wdata_ff == CODE_CHIP);
      sts.d_sector   = (wdata_ff == CODE_SECTOR);
      sts.d_stop     = (wdata_ff == CODE_STOP);
      sts.page_last  = (page_left_ff == PAGE_W'(1));
      sts.sweep_last = chip_ff ? (lin_ff == CELL_AW'(CELLS - 1)) : (&cnt_ff);
      sts.out_free   = !rsp_valid_ff || rsp_tready;
   end

endmodule

/* sv/bfcc_ctrl.sv */
`timescale 1ns / 1ps

module bfcc_ctrl
   import bfcc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   phase_type phase_ff, phase_in;
   mode_type  mode_ff, mode_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SWEEP;
         mode_ff  <= MODE_IDLE;
      end else begin
         phase_ff <= phase_in;
         mode_ff  <= mode_in;
      end
   end

   assign req_tready = (phase_ff == PH_IDLE);

   // next state
   always_comb begin
      phase_in = phase_ff;
      mode_in  = mode_ff;
      unique case (phase_ff)
         PH_SWEEP: if (sts.sweep_last) phase_in = PH_IDLE;
         PH_IDLE:  if (req_tvalid) phase_in = PH_EXEC;
         PH_EXEC: begin
            if (sts.out_free) begin
               phase_in = PH_IDLE;
               if (sts.is_write) begin
                  unique case (mode_ff)
                     MODE_IDLE:
                        if (sts.addr_a && sts.d_unlock_a) mode_in = MODE_UNLOCKED1;
                     MODE_UNLOCKED1:
                        if (sts.addr_b && sts.d_unlock_b) mode_in = MODE_COMMAND;
                     MODE_COMMAND: begin
                        if (sts.addr_a) begin
                           if (sts.d_bank) mode_in = MODE_BANKSEL;
                           else if (sts.d_id) mode_in = MODE_ID1;
                           else if (sts.d_program) mode_in = MODE_PROGRAM;
                           else if (sts.d_erase) mode_in = MODE_ER1;
                        end
                     end
                     MODE_ER1:  if (sts.addr_a && sts.d_unlock_a) mode_in = MODE_ER2;
                     MODE_IDX1: if (sts.addr_a && sts.d_unlock_a) mode_in = MODE_IDX2;
                     MODE_ER2:  if (sts.addr_b && sts.d_unlock_b) mode_in = MODE_ER3;
                     MODE_IDX2: if (sts.addr_b && sts.d_unlock_b) mode_in = MODE_IDX3;
                     MODE_ER3: begin
                        if (sts.d_chip || sts.d_sector) begin
                           mode_in  = MODE_IDLE;
                           phase_in = PH_SWEEP;
                        end
                     end
                     MODE_IDX3: if (sts.addr_a && sts.d_stop) mode_in = MODE_IDLE;
                     MODE_BANKSEL: if (sts.addr_zero) mode_in = MODE_IDLE;
                     MODE_PROGRAM: mode_in = MODE_AFTERPROG;
                     MODE_AFTERPROG: begin
                        if (sts.addr_a) begin
                           if (sts.d_unlock_a) mode_in = MODE_UNLOCKED1;
                           else if (sts.d_stop) mode_in = MODE_IDLE;
                        end else begin
                           mode_in = MODE_PAGE;
                        end
                     end
                     MODE_PAGE: if (sts.page_last) mode_in = MODE_IDLE;
                     default: mode_in = mode_ff;
                  endcase
               end else begin
                  if (mode_ff == MODE_ID1) mode_in = MODE_ID2;
                  else if (mode_ff == MODE_ID2) mode_in = MODE_IDX1;
               end
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd = '0;
      cmd.rsel = RSEL_ZERO;
      unique case (phase_ff)
         PH_SWEEP: cmd.sweep_step = 1'b1;
         PH_IDLE:  cmd.capture = req_tvalid;
         PH_EXEC: begin
            if (sts.out_free) begin
               cmd.exec = 1'b1;
               if (sts.is_write) begin
                  unique case (mode_ff)
                     MODE_IDLE:
                        cmd.error = !(sts.addr_a && (sts.d_unlock_a || sts.d_stop));
                     MODE_UNLOCKED1:
                        cmd.error = !(sts.addr_b && sts.d_unlock_b);
                     MODE_COMMAND:
                        cmd.error = !(sts.addr_a && (sts.d_bank || sts.d_id
                                                     || sts.d_program || sts.d_erase));
                     MODE_ER1, MODE_IDX1:
                        cmd.error = !(sts.addr_a && sts.d_unlock_a);
                     MODE_ER2, MODE_IDX2:
                        cmd.error = !(sts.addr_b && sts.d_unlock_b);
                     MODE_ER3: begin
                        cmd.chip_start   = sts.d_chip;
                        cmd.sector_start = sts.d_sector;
                        cmd.error        = !(sts.d_chip || sts.d_sector);
                     end
                     MODE_IDX3:
                        cmd.error = !(sts.addr_a && sts.d_stop);
                     MODE_BANKSEL: begin
                        cmd.bank_load = sts.addr_zero;
                        cmd.error     = !sts.addr_zero;
                     end
                     MODE_PROGRAM: cmd.mem_write = 1'b1;
                     MODE_AFTERPROG: begin
                        if (sts.addr_a) begin
                           cmd.error = !(sts.d_unlock_a || sts.d_stop);
                        end else begin
                           cmd.mem_write = 1'b1;
                           cmd.page_load = 1'b1;
                        end
                     end
                     MODE_PAGE: begin
                        cmd.mem_write = 1'b1;
                        cmd.page_dec  = 1'b1;
                     end
                     default: cmd.error = 1'b1;
                  endcase
               end else begin
                  cmd.rsel = (mode_ff == MODE_ID1 || mode_ff == MODE_ID2) ? RSEL_ID : RSEL_MEM;
               end
            end
         end
         default: cmd = '0;
      endcase
   end

endmodule

/* sv/banked_flash_command_controller.sv */
// Banked byte-wide flash with an unlock-sequence command interface.
// req channel: one word per bus access; tuser[0] is the kind (0 read, 1 write),
// tdata holds the address (bits 15:0) and the write byte (bits 23:16).
// rsp channel: one word per access; tdata is the read byte (zero on writes),
// tuser[0] flags a write that did not fit the expected command step.
// csr port: index 0 sets the ID byte for even addresses, index 1 for odd ones.
// The result is registered in the output register in the command step after
// the accept, once that register is free. An access has two steps (capture with
// the memory read, then the command step); no new word is taken before the last
// one's command step is done. Chip erase walks the whole array one byte a cycle
// (BANKS * BANK_BYTES bytes), sector erase walks 4096 bytes; req_tready stays
// low while the walk runs. After reset the same walk clears the array to 0xFF
// (131072 bytes with the defaults) before req_tready first rises; csr writes are
// taken meanwhile. A stalled rsp word holds in the output register; the next
// access is accepted but waits in its command step until the slot frees.
`timescale 1ns / 1ps
`include "banked_flash_command_controller_defines.svh"

module banked_flash_command_controller
   import bfcc_pkg::*;
#(
   parameter int BANKS      = 2,
   parameter int BANK_BYTES = 65536
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [23:0]          req_tdata,   // address[15:0], wdata[23:16]
   input  logic [0:0]           req_tuser,   // action[0]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // rdata[7:0]
   output logic [0:0]           rsp_tuser,   // protocol_error[0]
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   bfcc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bfcc_dp #(
      .BANKS      (BANKS),
      .BANK_BYTES (BANK_BYTES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // a command step must never overwrite a word still waiting on rsp
   `BFCC_ASSERT_SAME(a_exec_slot_free, clock, reset, cmd.exec, !rsp_tvalid || rsp_tready, "command step while output slot busy")
   // the array walk and new accesses exclude each other
   `BFCC_ASSERT_SAME(a_sweep_blocks_req, clock, reset, cmd.sweep_step, !req_tready && !cmd.mem_write, "access taken during erase walk")
   // an accepted word is followed by its command step, not another accept
   `BFCC_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready, "second word accepted before command step")

endmodule
